/* rtl/core/rpm_pkg.sv */
// ----------------------------------------------------------------------------
// rpm_pkg: shared definitions for the maze carver
// Sizes, codes, state and command types used by the controller and datapath.
// ----------------------------------------------------------------------------
package rpm_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int WALL_DEPTH = 4096;

	localparam int SIDE_W    = $clog2(MAX_SIDE);
	localparam int MAP_AW    = 2 * SIDE_W;
	localparam int MAP_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int WALL_AW   = $clog2(WALL_DEPTH);
	localparam int COUNT_W   = WALL_AW + 1;
	localparam int RAND_W    = 31;
	localparam int OP_W      = 2;
	localparam int OUT_W     = 6;
	localparam int CFG_DW    = 6;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CW    = $clog2(RAND_W + 1);
	localparam int SIDE_CAP  = (MAX_SIDE - 1) | 1;

	// Map entry bits: [1] visited, [0] open.
	localparam logic [1:0] MAP_WALL    = 2'b00;
	localparam logic [1:0] MAP_OPENED  = 2'b01;
	localparam logic [1:0] MAP_CLAIMED = 2'b11;

	typedef enum logic [OP_W-1:0] {
		OP_START = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_HEIGHT = 1'b0,
		CFG_GRID_WIDTH  = 1'b1
	} cfg_idx_e;

	typedef enum logic [1:0] {
		DIR_WEST  = 2'd0,
		DIR_NORTH = 2'd1,
		DIR_EAST  = 2'd2,
		DIR_SOUTH = 2'd3
	} dir_e;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_ST_DIVR, S_ST_WAITR, S_ST_DIVC, S_ST_WAITC, S_CLEAR,
		S_CLAIM, S_NB_CHK, S_NB_WAIT, S_ENTRY, S_EXIT, S_PK_DIV, S_PK_WAIT, S_PK_RD,
		S_PK_DATA, S_SH_CHK, S_SH_WR, S_VIS_CHK, S_CELL_RD, S_CELL_DATA, S_FIN
	} state_e;

	typedef enum logic [4:0] {
		DP_NONE, DP_LOAD, DP_INIT_START, DP_DIV_ROW, DP_LATCH_ROW, DP_DIV_COL,
		DP_LATCH_COL, DP_CLEAR, DP_CLAIM, DP_NB_READ, DP_NB_PUSH, DP_NB_SKIP,
		DP_ENTRY, DP_EXIT, DP_DIV_PICK, DP_LATCH_PICK, DP_PICK_READ, DP_PICK_DATA,
		DP_SHIFT_READ, DP_SHIFT_WRITE, DP_SHRINK, DP_CARVE, DP_CELL_SETUP,
		DP_CELL_READ, DP_CELL_DATA, DP_OUT
	} dp_op_e;

	typedef struct packed {
		logic   in_ready;
		dp_op_e op;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		op_e  op;
		logic count_zero;
		logic div_done;
		logic clr_last;
		logic nb_in;
		logic nb_free;
		logic dir_last;
		logic sh_more;
		logic visited;
		logic rd_in;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [SIDE_W-1:0] wr;
		logic [SIDE_W-1:0] wc;
		logic [SIDE_W-1:0] nr;
		logic [SIDE_W-1:0] nc;
	} wall_t;

	// Grid side in use: at least 3, odd, capped.
	function automatic logic [SIDE_W-1:0] side_from(input logic [CFG_DW-1:0] req);
		logic [CFG_DW:0] s;
		begin
			s = {1'b0, req};
			if (s < (CFG_DW+1)'(2))
				s = (CFG_DW+1)'(2);
			if (!s[0])
				s = s + (CFG_DW+1)'(1);
			if (s > (CFG_DW+1)'(SIDE_CAP))
				s = (CFG_DW+1)'(SIDE_CAP);
			return SIDE_W'(s);
		end
	endfunction

endpackage

/* rtl/core/rpm_if.sv */
// ----------------------------------------------------------------------------
// rpm_if: channel interfaces of the maze carver
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rpm_in_if;
	logic                        valid;
	logic                        ready;
	logic [rpm_pkg::OP_W-1:0]    op;
	logic [rpm_pkg::RAND_W-1:0]  rand_a;
	logic [rpm_pkg::RAND_W-1:0]  rand_b;
	logic [rpm_pkg::OUT_W-1:0]   read_row;
	logic [rpm_pkg::OUT_W-1:0]   read_col;
	modport source (output valid, op, rand_a, rand_b, read_row, read_col, input ready);
	modport sink (input valid, op, rand_a, rand_b, read_row, read_col, output ready);
endinterface

interface rpm_out_if;
	logic                        valid;
	logic                        ready;
	logic [rpm_pkg::OUT_W-1:0]   cell_row;
	logic [rpm_pkg::OUT_W-1:0]   cell_col;
	logic                        carved;
	logic                        list_empty;
	logic                        cell_open;
	modport source (output valid, cell_row, cell_col, carved, list_empty, cell_open,
		input ready);
	modport sink (input valid, cell_row, cell_col, carved, list_empty, cell_open,
		output ready);
endinterface

interface rpm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rpm_pkg::CFG_IDX_W-1:0] index;
	logic [rpm_pkg::CFG_DW-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/rpm_ram.sv */
// ----------------------------------------------------------------------------
// rpm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rpm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/rpm_div.sv */
// ----------------------------------------------------------------------------
// rpm_div: iterative remainder unit
// Restoring division, one dividend bit per cycle; gives the remainder only.
// ----------------------------------------------------------------------------
module rpm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rpm_pkg::RAND_W-1:0]   dividend,
	input  logic [rpm_pkg::COUNT_W-1:0]  divisor,
	output logic                         done,
	output logic [rpm_pkg::COUNT_W-1:0]  rem
);

	logic                        busy_q;
	logic                        done_q;
	logic [rpm_pkg::DIV_CW-1:0]  cnt_q;
	logic [rpm_pkg::RAND_W-1:0]  dvd_q;
	logic [rpm_pkg::COUNT_W-1:0] div_q;
	logic [rpm_pkg::COUNT_W-1:0] rem_q;
	logic [rpm_pkg::COUNT_W-1:0] trial;

	// The partial remainder stays below the divisor, so one more bit still fits.
	assign trial = {rem_q[rpm_pkg::COUNT_W-2:0], dvd_q[rpm_pkg::RAND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == rpm_pkg::DIV_CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rpm_pkg::DIV_CW'(rpm_pkg::RAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - rpm_pkg::DIV_CW'(1);
				if (cnt_q == rpm_pkg::DIV_CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[rpm_pkg::RAND_W-2:0], 1'b0};
			rem_q <= (trial >= div_q) ? trial - div_q : trial;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* rtl/core/rpm_ctrl.sv */
// ----------------------------------------------------------------------------
// rpm_ctrl: maze carver sequencer
// Walks each word through its steps: clearing, division, list shifting, carving or a cell read.
// ----------------------------------------------------------------------------
module rpm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  rpm_pkg::sts_t sts,
	output rpm_pkg::cmd_t cmd
);

	rpm_pkg::state_e state_q, state_d;
	rpm_pkg::state_e after_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rpm_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// A start word still has the entry and exit to open after its first push.
	assign after_push = (sts.op == rpm_pkg::OP_START) ? rpm_pkg::S_ENTRY : rpm_pkg::S_FIN;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpm_pkg::S_IDLE: if (sts.in_valid) state_d = rpm_pkg::S_DISPATCH;
			rpm_pkg::S_DISPATCH: begin
				unique case (sts.op)
					rpm_pkg::OP_START: state_d = rpm_pkg::S_ST_DIVR;
					rpm_pkg::OP_STEP: state_d = sts.count_zero ? rpm_pkg::S_FIN
						: rpm_pkg::S_PK_DIV;
					rpm_pkg::OP_READ: state_d = sts.rd_in ? rpm_pkg::S_CELL_RD
						: rpm_pkg::S_FIN;
					rpm_pkg::OP_NONE: state_d = rpm_pkg::S_FIN;
				endcase
			end
			rpm_pkg::S_ST_DIVR: state_d = rpm_pkg::S_ST_WAITR;
			rpm_pkg::S_ST_WAITR: if (sts.div_done) state_d = rpm_pkg::S_ST_DIVC;
			rpm_pkg::S_ST_DIVC: state_d = rpm_pkg::S_ST_WAITC;
			rpm_pkg::S_ST_WAITC: if (sts.div_done) state_d = rpm_pkg::S_CLEAR;
			rpm_pkg::S_CLEAR: if (sts.clr_last) state_d = rpm_pkg::S_CLAIM;
			rpm_pkg::S_CLAIM: state_d = rpm_pkg::S_NB_CHK;
			rpm_pkg::S_NB_CHK: begin
				if (sts.nb_in)
					state_d = rpm_pkg::S_NB_WAIT;
				else if (sts.dir_last)
					state_d = after_push;
			end
			rpm_pkg::S_NB_WAIT: state_d = sts.dir_last ? after_push : rpm_pkg::S_NB_CHK;
			rpm_pkg::S_ENTRY: state_d = rpm_pkg::S_EXIT;
			rpm_pkg::S_EXIT: state_d = rpm_pkg::S_FIN;
			rpm_pkg::S_PK_DIV: state_d = rpm_pkg::S_PK_WAIT;
			rpm_pkg::S_PK_WAIT: if (sts.div_done) state_d = rpm_pkg::S_PK_RD;
			rpm_pkg::S_PK_RD: state_d = rpm_pkg::S_PK_DATA;
			rpm_pkg::S_PK_DATA: state_d = rpm_pkg::S_SH_CHK;
			rpm_pkg::S_SH_CHK: state_d = sts.sh_more ? rpm_pkg::S_SH_WR : rpm_pkg::S_VIS_CHK;
			rpm_pkg::S_SH_WR: state_d = rpm_pkg::S_SH_CHK;
			rpm_pkg::S_VIS_CHK: state_d = sts.visited ? rpm_pkg::S_FIN : rpm_pkg::S_CLAIM;
			rpm_pkg::S_CELL_RD: state_d = rpm_pkg::S_CELL_DATA;
			rpm_pkg::S_CELL_DATA: state_d = rpm_pkg::S_FIN;
			rpm_pkg::S_FIN: if (sts.out_free) state_d = rpm_pkg::S_IDLE;
			default: state_d = rpm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.in_ready = 1'b0;
		cmd.op       = rpm_pkg::DP_NONE;
		unique case (state_q)
			rpm_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) cmd.op = rpm_pkg::DP_LOAD;
			end
			rpm_pkg::S_DISPATCH: begin
				if (sts.op == rpm_pkg::OP_START)
					cmd.op = rpm_pkg::DP_INIT_START;
				else if (sts.op == rpm_pkg::OP_READ)
					cmd.op = rpm_pkg::DP_CELL_SETUP;
			end
			rpm_pkg::S_ST_DIVR: cmd.op = rpm_pkg::DP_DIV_ROW;
			rpm_pkg::S_ST_WAITR: if (sts.div_done) cmd.op = rpm_pkg::DP_LATCH_ROW;
			rpm_pkg::S_ST_DIVC: cmd.op = rpm_pkg::DP_DIV_COL;
			rpm_pkg::S_ST_WAITC: if (sts.div_done) cmd.op = rpm_pkg::DP_LATCH_COL;
			rpm_pkg::S_CLEAR: cmd.op = rpm_pkg::DP_CLEAR;
			rpm_pkg::S_CLAIM: cmd.op = rpm_pkg::DP_CLAIM;
			rpm_pkg::S_NB_CHK: cmd.op = sts.nb_in ? rpm_pkg::DP_NB_READ : rpm_pkg::DP_NB_SKIP;
			rpm_pkg::S_NB_WAIT: cmd.op = sts.nb_free ? rpm_pkg::DP_NB_PUSH
				: rpm_pkg::DP_NB_SKIP;
			rpm_pkg::S_ENTRY: cmd.op = rpm_pkg::DP_ENTRY;
			rpm_pkg::S_EXIT: cmd.op = rpm_pkg::DP_EXIT;
			rpm_pkg::S_PK_DIV: cmd.op = rpm_pkg::DP_DIV_PICK;
			rpm_pkg::S_PK_WAIT: if (sts.div_done) cmd.op = rpm_pkg::DP_LATCH_PICK;
			rpm_pkg::S_PK_RD: cmd.op = rpm_pkg::DP_PICK_READ;
			rpm_pkg::S_PK_DATA: cmd.op = rpm_pkg::DP_PICK_DATA;
			rpm_pkg::S_SH_CHK: cmd.op = sts.sh_more ? rpm_pkg::DP_SHIFT_READ
				: rpm_pkg::DP_SHRINK;
			rpm_pkg::S_SH_WR: cmd.op = rpm_pkg::DP_SHIFT_WRITE;
			rpm_pkg::S_VIS_CHK: if (!sts.visited) cmd.op = rpm_pkg::DP_CARVE;
			rpm_pkg::S_CELL_RD: cmd.op = rpm_pkg::DP_CELL_READ;
			rpm_pkg::S_CELL_DATA: cmd.op = rpm_pkg::DP_CELL_DATA;
			rpm_pkg::S_FIN: if (sts.out_free) cmd.op = rpm_pkg::DP_OUT;
			default: cmd.op = rpm_pkg::DP_NONE;
		endcase
	end

endmodule

/* rtl/core/rpm_datapath.sv */
// ----------------------------------------------------------------------------
// rpm_datapath: maze carver storage and arithmetic
// Cell map, wall list, remainder unit, configuration and result registers.
// ----------------------------------------------------------------------------
module rpm_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  rpm_pkg::cmd_t cmd,
	output rpm_pkg::sts_t sts,
	rpm_in_if.sink        in_ch,
	rpm_out_if.source     out_ch,
	rpm_cfg_if.sink       cfg_ch
);

	localparam int SW = rpm_pkg::SIDE_W;
	localparam int OW = rpm_pkg::OUT_W;
	localparam int CW = rpm_pkg::COUNT_W;
	localparam int WA = rpm_pkg::WALL_AW;
	localparam int MA = rpm_pkg::MAP_AW;

	logic [rpm_pkg::CFG_DW-1:0] height_q, width_q;
	logic [SW-1:0]              rows_q, cols_q;
	logic [CW-1:0]              count_q;
	logic                       out_valid_q;

	logic [rpm_pkg::OP_W-1:0]   op_q;
	logic [rpm_pkg::RAND_W-1:0] ra_q, rb_q;
	logic [OW-1:0]              rr_q, rc_q;
	logic [WA-1:0]              idx_q;
	logic [MA-1:0]              clr_q;
	logic [1:0]                 dir_q;
	logic [SW-1:0]              cur_r_q, cur_c_q, wall_r_q, wall_c_q;
	logic [OW-1:0]              res_row_q, res_col_q;
	logic                       carved_q, open_q;
	logic [OW-1:0]              out_row_q, out_col_q;
	logic                       out_carved_q, out_empty_q, out_open_q;

	logic [SW:0]                nb_r_x, nb_c_x, wl_r_x, wl_c_x;
	logic                       nb_in;
	logic [SW-1:0]              nb_r, nb_c, wl_r, wl_c;

	logic                       map_we;
	logic [MA-1:0]              map_waddr, map_raddr;
	logic [1:0]                 map_wdata, map_rdata;
	logic                       wl_we;
	logic [WA-1:0]              wl_waddr, wl_raddr;
	rpm_pkg::wall_t             wl_wdata, wl_rdata;

	logic                       div_start, div_done;
	logic [rpm_pkg::RAND_W-1:0] div_dvd;
	logic [CW-1:0]              div_dvs, div_rem;

	assign in_ch.ready  = cmd.in_ready;
	assign cfg_ch.ready = 1'b1;

	// Neighbour two cells away in the current direction, and the wall between.
	always_comb begin
		nb_r_x = {1'b0, cur_r_q};
		nb_c_x = {1'b0, cur_c_q};
		wl_r_x = {1'b0, cur_r_q};
		wl_c_x = {1'b0, cur_c_q};
		nb_in  = 1'b0;
		unique case (rpm_pkg::dir_e'(dir_q))
			rpm_pkg::DIR_WEST: begin
				nb_c_x = {1'b0, cur_c_q} - (SW+1)'(2);
				wl_c_x = {1'b0, cur_c_q} - (SW+1)'(1);
				nb_in  = cur_c_q >= SW'(2);
			end
			rpm_pkg::DIR_NORTH: begin
				nb_r_x = {1'b0, cur_r_q} - (SW+1)'(2);
				wl_r_x = {1'b0, cur_r_q} - (SW+1)'(1);
				nb_in  = cur_r_q >= SW'(2);
			end
			rpm_pkg::DIR_EAST: begin
				nb_c_x = {1'b0, cur_c_q} + (SW+1)'(2);
				wl_c_x = {1'b0, cur_c_q} + (SW+1)'(1);
				nb_in  = nb_c_x < {1'b0, cols_q};
			end
			rpm_pkg::DIR_SOUTH: begin
				nb_r_x = {1'b0, cur_r_q} + (SW+1)'(2);
				wl_r_x = {1'b0, cur_r_q} + (SW+1)'(1);
				nb_in  = nb_r_x < {1'b0, rows_q};
			end
		endcase
	end

	assign nb_r = nb_r_x[SW-1:0];
	assign nb_c = nb_c_x[SW-1:0];
	assign wl_r = wl_r_x[SW-1:0];
	assign wl_c = wl_c_x[SW-1:0];

	always_comb begin
		map_we    = 1'b0;
		map_waddr = {cur_r_q, cur_c_q};
		map_wdata = rpm_pkg::MAP_CLAIMED;
		map_raddr = {nb_r, nb_c};
		unique case (cmd.op)
			rpm_pkg::DP_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = rpm_pkg::MAP_WALL;
			end
			rpm_pkg::DP_CLAIM: map_we = 1'b1;
			rpm_pkg::DP_CARVE: begin
				map_we    = 1'b1;
				map_waddr = {wall_r_q, wall_c_q};
				map_wdata = rpm_pkg::MAP_OPENED;
			end
			rpm_pkg::DP_ENTRY: begin
				map_we    = 1'b1;
				map_waddr = {SW'(1), SW'(0)};
				map_wdata = rpm_pkg::MAP_OPENED;
			end
			rpm_pkg::DP_EXIT: begin
				map_we    = 1'b1;
				map_waddr = {rows_q - SW'(2), cols_q - SW'(1)};
				map_wdata = rpm_pkg::MAP_OPENED;
			end
			rpm_pkg::DP_SHRINK: map_raddr = {cur_r_q, cur_c_q};
			rpm_pkg::DP_CELL_READ: map_raddr = {SW'(rr_q), SW'(rc_q)};
			default: map_we = 1'b0;
		endcase
	end

	always_comb begin
		wl_we    = 1'b0;
		wl_waddr = idx_q;
		wl_wdata = wl_rdata;
		wl_raddr = idx_q;
		unique case (cmd.op)
			rpm_pkg::DP_NB_PUSH: begin
				wl_we    = 1'b1;
				wl_waddr = count_q[WA-1:0];
				wl_wdata = '{wr: wl_r, wc: wl_c, nr: nb_r, nc: nb_c};
			end
			rpm_pkg::DP_SHIFT_WRITE: wl_we = 1'b1;
			rpm_pkg::DP_SHIFT_READ: wl_raddr = idx_q + WA'(1);
			default: wl_we = 1'b0;
		endcase
	end

	rpm_ram #(.WIDTH(2), .DEPTH(rpm_pkg::MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	rpm_ram #(.WIDTH($bits(rpm_pkg::wall_t)), .DEPTH(rpm_pkg::WALL_DEPTH)) u_walls (
		.clk   (clk),
		.we    (wl_we),
		.waddr (wl_waddr),
		.wdata (wl_wdata),
		.raddr (wl_raddr),
		.rdata (wl_rdata)
	);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = ra_q;
		div_dvs   = count_q;
		unique case (cmd.op)
			rpm_pkg::DP_DIV_ROW: begin
				div_start = 1'b1;
				div_dvs   = CW'(rows_q >> 1);
			end
			rpm_pkg::DP_DIV_COL: begin
				div_start = 1'b1;
				div_dvd   = rb_q;
				div_dvs   = CW'(cols_q >> 1);
			end
			rpm_pkg::DP_DIV_PICK: div_start = 1'b1;
			default: div_start = 1'b0;
		endcase
	end

	rpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= rpm_pkg::CFG_DW'(63);
			width_q  <= rpm_pkg::CFG_DW'(63);
		end else if (cfg_ch.valid) begin
			unique case (rpm_pkg::cfg_idx_e'(cfg_ch.index))
				rpm_pkg::CFG_GRID_HEIGHT: height_q <= cfg_ch.data;
				rpm_pkg::CFG_GRID_WIDTH: width_q <= cfg_ch.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= '0;
			cols_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == rpm_pkg::DP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (cmd.op)
				rpm_pkg::DP_INIT_START: begin
					rows_q  <= rpm_pkg::side_from(height_q);
					cols_q  <= rpm_pkg::side_from(width_q);
					count_q <= '0;
				end
				rpm_pkg::DP_NB_PUSH: count_q <= count_q + CW'(1);
				rpm_pkg::DP_SHRINK: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rpm_pkg::DP_LOAD: begin
				op_q      <= in_ch.op;
				ra_q      <= in_ch.rand_a;
				rb_q      <= in_ch.rand_b;
				rr_q      <= in_ch.read_row;
				rc_q      <= in_ch.read_col;
				res_row_q <= '0;
				res_col_q <= '0;
				carved_q  <= 1'b0;
				open_q    <= 1'b0;
			end
			rpm_pkg::DP_INIT_START: clr_q <= '0;
			rpm_pkg::DP_LATCH_ROW: cur_r_q <= SW'({div_rem, 1'b1});
			rpm_pkg::DP_LATCH_COL: cur_c_q <= SW'({div_rem, 1'b1});
			rpm_pkg::DP_CLEAR: clr_q <= clr_q + MA'(1);
			rpm_pkg::DP_CLAIM: dir_q <= 2'(rpm_pkg::DIR_WEST);
			rpm_pkg::DP_NB_PUSH, rpm_pkg::DP_NB_SKIP: dir_q <= dir_q + 2'd1;
			rpm_pkg::DP_ENTRY: begin
				res_row_q <= OW'(cur_r_q);
				res_col_q <= OW'(cur_c_q);
			end
			rpm_pkg::DP_LATCH_PICK: idx_q <= WA'(div_rem);
			rpm_pkg::DP_PICK_DATA: begin
				wall_r_q  <= wl_rdata.wr;
				wall_c_q  <= wl_rdata.wc;
				cur_r_q   <= wl_rdata.nr;
				cur_c_q   <= wl_rdata.nc;
				res_row_q <= OW'(wl_rdata.wr);
				res_col_q <= OW'(wl_rdata.wc);
			end
			rpm_pkg::DP_SHIFT_WRITE: idx_q <= idx_q + WA'(1);
			rpm_pkg::DP_CARVE: carved_q <= 1'b1;
			rpm_pkg::DP_CELL_SETUP: begin
				res_row_q <= rr_q;
				res_col_q <= rc_q;
			end
			rpm_pkg::DP_CELL_DATA: open_q <= map_rdata[0];
			rpm_pkg::DP_OUT: begin
				out_row_q    <= res_row_q;
				out_col_q    <= res_col_q;
				out_carved_q <= carved_q;
				out_empty_q  <= (count_q == '0);
				out_open_q   <= open_q;
			end
			default: op_q <= op_q;
		endcase
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.cell_row   = out_row_q;
	assign out_ch.cell_col   = out_col_q;
	assign out_ch.carved     = out_carved_q;
	assign out_ch.list_empty = out_empty_q;
	assign out_ch.cell_open  = out_open_q;

	always_comb begin
		sts.in_valid   = in_ch.valid;
		sts.op         = rpm_pkg::op_e'(op_q);
		sts.count_zero = (count_q == '0);
		sts.div_done   = div_done;
		sts.clr_last   = &clr_q;
		sts.nb_in      = nb_in;
		sts.nb_free    = !map_rdata[0] && (count_q < CW'(rpm_pkg::WALL_DEPTH));
		sts.dir_last   = (dir_q == 2'(rpm_pkg::DIR_SOUTH));
		sts.sh_more    = (CW'(idx_q) + CW'(1)) < count_q;
		sts.visited    = map_rdata[1];
		sts.rd_in      = ((OW+SW)'(rr_q) < (OW+SW)'(rows_q))
			&& ((OW+SW)'(rc_q) < (OW+SW)'(cols_q));
		sts.out_free   = !out_valid_q || out_ch.ready;
	end

endmodule

/* rtl/core/random_prim_maze_carver.sv */
// A read word does at most one cell-map read; a start word runs two remainder passes
// and one sweep of all 4096 cell-map entries; a step word on a non-empty list runs one
// remainder pass, then a wall-list shift that grows with the entries behind the picked wall.
// One word is in work at a time; the next is taken once the result is registered.
// Reset makes the grid size 63 by 63 and empties the wall list; no clearing pass
// runs, as every cell reads as a wall until the first start word.
// ----------------------------------------------------------------------------
// random_prim_maze_carver: randomised Prim maze generator
// Sequencer and datapath building a maze one word at a time.
// ----------------------------------------------------------------------------
module random_prim_maze_carver (
	input  logic      clk,
	input  logic      arst_n,
	rpm_in_if.sink    in_ch,
	rpm_out_if.source out_ch,
	rpm_cfg_if.sink   cfg_ch
);

	rpm_pkg::cmd_t cmd;
	rpm_pkg::sts_t sts;

	rpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	rpm_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

endmodule

/* rtl/core/rpm_checker.sv */
// ----------------------------------------------------------------------------
// rpm_checker: port-level checks for the maze carver
// Watches the handshakes and result words seen at the top level.
// ----------------------------------------------------------------------------
module rpm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [rpm_pkg::OUT_W-1:0] cell_row,
	input logic [rpm_pkg::OUT_W-1:0] cell_col,
	input logic                      carved,
	input logic                      cell_open
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cell_row) && $stable(cell_col))
		else $error("stalled result word changed");

	// Only one word is in work at a time.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(carved && cell_open))
		else $error("carved and cell_open both set");

	// A wall lies between two cells, so exactly one coordinate is odd.
	a_wall_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carved |-> cell_row[0] != cell_col[0])
		else $error("carved wall at a cell position");

endmodule

bind random_prim_maze_carver rpm_checker u_rpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.cell_row  (out_ch.cell_row),
	.cell_col  (out_ch.cell_col),
	.carved    (out_ch.carved),
	.cell_open (out_ch.cell_open)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the maze carver
// Drives start, step, read and idle words with random idling on both channels,
// predicts every result word with a model of the carving algorithm, compares
// the words field by field, and changes the grid size between phases.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [rpm_pkg::OP_W-1:0]   op;
		logic [rpm_pkg::RAND_W-1:0] ra;
		logic [rpm_pkg::RAND_W-1:0] rb;
		logic [rpm_pkg::OUT_W-1:0]  rr;
		logic [rpm_pkg::OUT_W-1:0]  rc;
	} word_t;

	typedef struct packed {
		logic [rpm_pkg::OUT_W-1:0] row;
		logic [rpm_pkg::OUT_W-1:0] col;
		logic                      carved;
		logic                      empty;
		logic                      open;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;
	rpm_in_if  in_ch();
	rpm_out_if out_ch();
	rpm_cfg_if cfg_ch();

	random_prim_maze_carver dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .cfg_ch(cfg_ch));

	always #5 clk = ~clk;

	// Maze model state.
	bit             open_m [rpm_pkg::MAP_DEPTH];
	bit             seen_m [rpm_pkg::MAP_DEPTH];
	rpm_pkg::wall_t walls [$];
	int             rows_m, cols_m;
	logic [5:0]     req_h = 63, req_w = 63;

	word_t pending [$];
	res_t  expected [$];
	int    mismatches, results, carves, idle_off, cfg_writes;

	function automatic int side_of(int req);
		int s;
		s = req < 2 ? 2 : req;
		if (s % 2 == 0) s++;
		if (s > rpm_pkg::SIDE_CAP) s = rpm_pkg::SIDE_CAP;
		return s;
	endfunction

	function automatic void push_walls(int r, int c);
		int dr [4] = '{0, -1, 0, 1};
		int dc [4] = '{-1, 0, 1, 0};
		int nr, nc;
		rpm_pkg::wall_t w;
		for (int k = 0; k < 4; k++) begin
			nr = r + 2 * dr[k];
			nc = c + 2 * dc[k];
			if (nr < 0 || nr >= rows_m || nc < 0 || nc >= cols_m) continue;
			if (open_m[nr * rpm_pkg::MAX_SIDE + nc]) continue;
			if (walls.size() >= rpm_pkg::WALL_DEPTH) continue;
			w.wr = rpm_pkg::SIDE_W'(r + dr[k]);
			w.wc = rpm_pkg::SIDE_W'(c + dc[k]);
			w.nr = rpm_pkg::SIDE_W'(nr);
			w.nc = rpm_pkg::SIDE_W'(nc);
			walls = {walls, w};
		end
	endfunction

	function automatic void claim_cell(int r, int c);
		seen_m[r * rpm_pkg::MAX_SIDE + c] = 1;
		open_m[r * rpm_pkg::MAX_SIDE + c] = 1;
		push_walls(r, c);
	endfunction

	function automatic res_t carve_word(word_t x);
		res_t o;
		int sr, sc, idx;
		rpm_pkg::wall_t w;
		o = '0;
		case (rpm_pkg::op_e'(x.op))
			rpm_pkg::OP_START: begin
				rows_m = side_of(req_h);
				cols_m = side_of(req_w);
				foreach (open_m[i]) begin
					open_m[i] = 0;
					seen_m[i] = 0;
				end
				walls.delete();
				sr = 1 + (x.ra % (rows_m / 2)) * 2;
				sc = 1 + (x.rb % (cols_m / 2)) * 2;
				claim_cell(sr, sc);
				open_m[1 * rpm_pkg::MAX_SIDE] = 1;
				open_m[(rows_m - 2) * rpm_pkg::MAX_SIDE + cols_m - 1] = 1;
				o.row = rpm_pkg::OUT_W'(sr);
				o.col = rpm_pkg::OUT_W'(sc);
			end
			rpm_pkg::OP_STEP: begin
				if (walls.size() != 0) begin
					idx = x.ra % walls.size();
					w = walls[idx];
					walls.delete(idx);
					o.row = w.wr; o.col = w.wc;
					if (!seen_m[w.nr * rpm_pkg::MAX_SIDE + w.nc]) begin
						open_m[w.wr * rpm_pkg::MAX_SIDE + w.wc] = 1;
						claim_cell(w.nr, w.nc);
						o.carved = 1;
					end
				end
			end
			rpm_pkg::OP_READ: begin
				o.row = x.rr; o.col = x.rc;
				if (x.rr < rows_m && x.rc < cols_m)
					o.open = open_m[x.rr * rpm_pkg::MAX_SIDE + x.rc];
			end
			default: ;
		endcase
		o.empty = walls.size() == 0;
		return o;
	endfunction

	// Sender: idles in bursts unless idling is switched off.
	int    in_gap;
	res_t  pred_r;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				pred_r = carve_word(pending.pop_front());
				expected = {expected, pred_r};
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 0;
				end else if (!idle_off && $urandom_range(0, 5) == 0) begin
					in_gap = $urandom_range(0, 4);
					in_ch.valid <= 0;
				end else if (pending.size() > 0) begin
					in_ch.valid    <= 1;
					in_ch.op       <= pending[0].op;
					in_ch.rand_a   <= pending[0].ra;
					in_ch.rand_b   <= pending[0].rb;
					in_ch.read_row <= pending[0].rr;
					in_ch.read_col <= pending[0].rc;
				end else
					in_ch.valid <= 0;
			end
		end
	end

	// Receiver: stalls in bursts, checks each word against the oldest expectation.
	int out_gap;
	res_t got, exp_r;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			out_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.cell_row, out_ch.cell_col, out_ch.carved,
					out_ch.list_empty, out_ch.cell_open};
				results++;
				if (expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", got);
				end else begin
					exp_r = expected.pop_front();
					carves += got.carved;
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: row %0d/%0d col %0d/%0d carved %0b/%0b empty %0b/%0b open %0b/%0b (exp/got)",
								exp_r.row, got.row, exp_r.col, got.col, exp_r.carved,
								got.carved, exp_r.empty, got.empty, exp_r.open, got.open);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 0;
			end else if (!idle_off && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 4);
				out_ch.ready <= 0;
			end else
				out_ch.ready <= 1;
		end
	end

	task automatic add_word(rpm_pkg::op_e op, int ra, int rb, int rr, int rc);
		word_t x;
		x.op = op;
		x.ra = rpm_pkg::RAND_W'(ra);
		x.rb = rpm_pkg::RAND_W'(rb);
		x.rr = rpm_pkg::OUT_W'(rr);
		x.rc = rpm_pkg::OUT_W'(rc);
		pending = {pending, x};
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !in_ch.valid);
		@(posedge clk);
		wait (expected.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(rpm_pkg::cfg_idx_e idx, logic [5:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		if (idx == rpm_pkg::CFG_GRID_HEIGHT) req_h = val; else req_w = val;
		cfg_writes++;
	endtask

	// Start a maze then mostly steps, with reads and the odd unused op.
	task automatic random_maze(int n);
		int p;
		add_word(rpm_pkg::OP_START, $urandom() >> 1, $urandom() >> 1, 0, 0);
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 9);
			if (p < 6)
				add_word(rpm_pkg::OP_STEP, $urandom() >> 1, $urandom() >> 1,
					$urandom_range(0, 63), $urandom_range(0, 63));
			else if (p < 9)
				add_word(rpm_pkg::OP_READ, $urandom() >> 1, $urandom() >> 1,
					$urandom_range(0, 63), $urandom_range(0, 63));
			else
				add_word(rpm_pkg::OP_NONE, $urandom() >> 1, $urandom() >> 1,
					$urandom_range(0, 63), $urandom_range(0, 63));
		end
	endtask

	initial begin
		in_ch.op = 0; in_ch.rand_a = 0; in_ch.rand_b = 0;
		in_ch.read_row = 0; in_ch.read_col = 0;
		cfg_ch.valid = 0; cfg_ch.index = rpm_pkg::CFG_GRID_HEIGHT; cfg_ch.data = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// Directed: behaviour before any start, then a small maze at the extremes.
		add_word(rpm_pkg::OP_STEP, 5, 0, 0, 0);
		add_word(rpm_pkg::OP_READ, 0, 0, 1, 0);
		add_word(rpm_pkg::OP_NONE, '1, '1, '1, '1);
		drain();
		write_reg(rpm_pkg::CFG_GRID_HEIGHT, 0);
		write_reg(rpm_pkg::CFG_GRID_WIDTH, 1);
		add_word(rpm_pkg::OP_START, '1, '1, 0, 0);
		for (int i = 0; i < 6; i++) add_word(rpm_pkg::OP_STEP, 31'h7fffffff - i, 0, 0, 0);
		add_word(rpm_pkg::OP_READ, 0, 0, 1, 0);
		add_word(rpm_pkg::OP_READ, 0, 0, 1, 2);
		add_word(rpm_pkg::OP_READ, 0, 0, 63, 63);
		add_word(rpm_pkg::OP_READ, 0, 0, 2, 1);
		add_word(rpm_pkg::OP_NONE, 0, 0, 0, 0);
		drain();
		write_reg(rpm_pkg::CFG_GRID_HEIGHT, 63);
		write_reg(rpm_pkg::CFG_GRID_WIDTH, 2);
		add_word(rpm_pkg::OP_START, 0, 0, 0, 0);
		for (int i = 0; i < 4; i++) add_word(rpm_pkg::OP_STEP, i, '1, 0, 0);
		add_word(rpm_pkg::OP_READ, '1, '1, 61, 2);
		add_word(rpm_pkg::OP_READ, 0, 0, 62, 0);
		drain();

		// Random phases at assorted sizes; the large ones are kept short.
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(rpm_pkg::CFG_GRID_HEIGHT, ph == 4 ? 63 : $urandom_range(2, 12));
			write_reg(rpm_pkg::CFG_GRID_WIDTH, ph == 4 ? 62 : $urandom_range(2, 12));
			if (ph == 4) idle_off = 1;
			random_maze(ph == 4 ? 20 : 22);
			drain();
		end

		$display("covered %0d result words, %0d carved walls, %0d register writes",
			results, carves, cfg_writes);
		if (mismatches == 0 && expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#100000000;
		$display("status: fail");
		$finish;
	end

endmodule
